@@ sv/slips_pkg.sv @@
// ----------------------------------------------------------------------------
// slips_pkg: shared types and constants of the sorted list
// Capacity, widths, command codes and the structs that pass between modules.
// ----------------------------------------------------------------------------
package slips_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_op_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] head;
    logic [CNT_W-1:0]         count;
  } res_t;

endpackage

@@ sv/slips_cell.sv @@
// ----------------------------------------------------------------------------
// slips_cell: one entry of the sorted list
// Holds a word, compares it with the incoming value and shifts towards the
// tail on insert or towards the head on remove.
// ----------------------------------------------------------------------------
module slips_cell
  import slips_pkg::*;
(
  input  logic                     clk_i,
  input  cell_op_t                 op_i,
  input  logic                     valid_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     left_ge_i,
  input  logic signed [DATA_W-1:0] left_entry_i,
  input  logic signed [DATA_W-1:0] right_entry_i,
  output logic                     ge_o,
  output logic                     match_o,
  output logic signed [DATA_W-1:0] entry_o
);

  logic signed [DATA_W-1:0] entry_q, entry_d;

  assign ge_o    = !valid_i || !(entry_q < value_i);
  assign match_o = valid_i && (entry_q == value_i);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (op_i.ins && ge_o) begin
      entry_d = left_ge_i ? left_entry_i : value_i;
    end else if (op_i.rem) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ sv/slips_out.sv @@
// ----------------------------------------------------------------------------
// slips_out: result register of the sorted list
// Encodes the first-hit vector into an index and holds the result beat
// until the receiver takes it.
// ----------------------------------------------------------------------------
module slips_out
  import slips_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  res_t                     res_i,
  input  logic [CAPACITY-1:0]      hit_i,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic                     ok_o,
  output logic signed [DATA_W-1:0] head_value_o,
  output logic [IDX_W-1:0]         found_index_o,
  output logic [CNT_W-1:0]         count_o
);

  logic             valid_q, valid_d;
  res_t             res_q;
  logic [IDX_W-1:0] idx_q, idx_d;

  always_comb begin
    idx_d = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_i[i]) begin
        idx_d = idx_d | IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_d = valid_q && out_stall_i;
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
      idx_q <= idx_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign ok_o          = res_q.ok;
  assign head_value_o  = res_q.head;
  assign found_index_o = idx_q;
  assign count_o       = res_q.count;

endmodule

@@ sv/sorted_list_insert_pop_search_top.sv @@
// ----------------------------------------------------------------------------
// sorted_list_insert_pop_search_top: sorted list of signed words
// Keeps up to CAPACITY words in ascending order in a row of cells.
// ----------------------------------------------------------------------------
// Input beats carry a command and a value: insert keeps the list ascending
// and fails when the list is full, remove returns the smallest entry and
// fails when the list is empty, and search returns the lowest index whose
// entry equals the value. Every input beat gives exactly one result beat
// with ok, head_value, found_index and the entry count after the command.
// All cells compare and shift in the cycle that a beat is accepted, so the
// list is up to date for the next beat at once. The result passes through
// one stage that holds the first-hit vector and then the output register,
// where the index is encoded. One beat is taken each cycle while the
// receiver keeps up. When the receiver stalls, the output register holds
// its beat, the middle stage fills, and then in_stall_o rises until the
// output moves on. Reset empties the list; the entries themselves are not
// cleared.
// ----------------------------------------------------------------------------
module sorted_list_insert_pop_search_top
  import slips_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               cmd_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     ok_o,
  output logic signed [DATA_W-1:0] head_value_o,
  output logic [IDX_W-1:0]         found_index_o,
  output logic [CNT_W-1:0]         count_o
);

  logic                     in_acc;
  logic                     s1_valid_q, s1_valid_d;
  logic                     s1_move;
  res_t                     s1_res_q, s1_res_d;
  logic [CAPACITY-1:0]      s1_hit_q, s1_hit_d;
  logic [CNT_W-1:0]         count_q, count_d;
  cell_op_t                 op;
  logic [CAPACITY-1:0]      ge, match, first;
  logic signed [DATA_W-1:0] entry [CAPACITY];
  logic                     is_ins, is_rem, is_srch;

  assign s1_move    = s1_valid_q && !(out_valid_o && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign is_ins  = (cmd_i == CMD_INSERT);
  assign is_rem  = (cmd_i == CMD_REMOVE);
  assign is_srch = (cmd_i == CMD_SEARCH);

  assign op.ins = in_acc && is_ins && (count_q < CNT_W'(CAPACITY));
  assign op.rem = in_acc && is_rem && (count_q != '0);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                     left_ge;
    logic signed [DATA_W-1:0] left_entry, right_entry;

    if (g == 0) begin : g_first
      assign left_ge    = 1'b0;
      assign left_entry = value_i;
      assign first[g]   = match[g];
    end else begin : g_mid
      assign left_ge    = ge[g-1];
      assign left_entry = entry[g-1];
      assign first[g]   = match[g] && !match[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_entry = entry[g];
    end else begin : g_inner
      assign right_entry = entry[g+1];
    end

    slips_cell u_cell (
      .clk_i        (clk_i),
      .op_i         (op),
      .valid_i      (CNT_W'(g) < count_q),
      .value_i      (value_i),
      .left_ge_i    (left_ge),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .ge_o         (ge[g]),
      .match_o      (match[g]),
      .entry_o      (entry[g])
    );
  end

  always_comb begin
    count_d = count_q;
    if (op.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (op.rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    s1_res_d.ok    = op.ins || op.rem || (is_srch && (|first));
    s1_res_d.head  = op.rem ? entry[0] : '0;
    s1_res_d.count = count_d;
    s1_hit_d       = is_srch ? first : '0;
    s1_valid_d     = in_acc || (s1_valid_q && !s1_move);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      count_q    <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_res_q <= s1_res_d;
      s1_hit_q <= s1_hit_d;
    end
  end

  slips_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (s1_move),
    .res_i        (s1_res_q),
    .hit_i        (s1_hit_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .ok_o         (ok_o),
    .head_value_o (head_value_o),
    .found_index_o(found_index_o),
    .count_o      (count_o)
  );

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("Entry count exceeds the capacity.");

  a_count_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(count_q))
    else $error("Entry count changed without an accepted beat.");

  a_hit_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $onehot0(s1_hit_q))
    else $error("More than one first hit in the search result.");

  a_empty_remove : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_rem && (count_q == '0)) |=> !s1_res_q.ok)
    else $error("Remove from an empty list reported success.");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o))
    else $error("Input stalled while the result path had room.");

endmodule

@@ tb/tb_sorted_list_insert_pop_search_top.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_pop_search_top: self-checking bench for the sorted list
// Feeds insert, remove, search and unused-code beats through the input
// channel and checks every result beat against a local model of the list.
// The bench covers an empty list, a full list, duplicates and the extremes
// of the signed range. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_pop_search_top;
  import slips_pkg::*;

  localparam logic [1:0] CMD_NOP     = 2'd3;
  localparam int         IDLE_PCT    = 17;
  localparam int         QUIET_LIMIT = 2000;
  localparam int         RANDOM_CMDS = 650;

  typedef struct {
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] value;
    bit                       drain_first;
  } request_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] head;
    logic [IDX_W-1:0]         index;
    logic [CNT_W-1:0]         count;
  } outcome_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [1:0]               cmd_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic                     ok_o;
  logic signed [DATA_W-1:0] head_value_o;
  logic [IDX_W-1:0]         found_index_o;
  logic [CNT_W-1:0]         count_o;

  request_t                 pending_requests[$];
  outcome_t                 expected_outcomes[$];
  logic signed [DATA_W-1:0] list_words[CAPACITY];
  int                       list_fill;
  int                       sent_count;
  int                       checked_count;
  int                       error_count;
  int                       full_rejects;
  int                       empty_rejects;
  int                       search_hits;
  int                       quiet_cycles;
  logic                     calm;

  sorted_list_insert_pop_search_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ok_o         (ok_o),
    .head_value_o (head_value_o),
    .found_index_o(found_index_o),
    .count_o      (count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Neither side idles while this stretch of commands goes through.
  assign calm = (sent_count >= 300) && (sent_count < 420);

  task automatic queue_request(input logic [1:0] cmd, input logic signed [DATA_W-1:0] value,
                               input bit drain_first);
    request_t req;
    req.cmd         = cmd;
    req.value       = value;
    req.drain_first = drain_first;
    pending_requests.push_back(req);
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 30) begin
      $display("mismatch: %s", msg);
    end
  endtask

  // Applies one command to the local copy of the list and queues its result.
  task automatic apply_command(input logic [1:0] cmd, input logic signed [DATA_W-1:0] value);
    outcome_t res;
    int       pos;
    res = '0;
    case (cmd)
      CMD_INSERT: begin
        if (list_fill < CAPACITY) begin
          pos = list_fill;
          for (int i = 0; i < list_fill; i++) begin
            if (!(list_words[i] < value)) begin
              pos = i;
              break;
            end
          end
          for (int i = list_fill; i > pos; i--) begin
            list_words[i] = list_words[i-1];
          end
          list_words[pos] = value;
          list_fill++;
          res.ok = 1'b1;
        end else begin
          full_rejects++;
        end
      end
      CMD_REMOVE: begin
        if (list_fill > 0) begin
          res.head = list_words[0];
          for (int i = 0; i + 1 < list_fill; i++) begin
            list_words[i] = list_words[i+1];
          end
          list_fill--;
          res.ok = 1'b1;
        end else begin
          empty_rejects++;
        end
      end
      CMD_SEARCH: begin
        for (int i = 0; i < list_fill; i++) begin
          if (list_words[i] == value) begin
            res.ok    = 1'b1;
            res.index = i[IDX_W-1:0];
            search_hits++;
            break;
          end
        end
      end
      default: begin
      end
    endcase
    res.count = list_fill[CNT_W-1:0];
    expected_outcomes.push_back(res);
  endtask

  always @(posedge clk_i) begin
    request_t req;
    logic     free;
    if (rst_ni) begin
      free = !in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        apply_command(cmd_i, value_i);
        sent_count++;
        free = 1'b1;
      end
      if (free) begin
        if (pending_requests.size() != 0
            && !(pending_requests[0].drain_first && expected_outcomes.size() != 0)
            && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          req = pending_requests.pop_front();
          cmd_i      <= req.cmd;
          value_i    <= req.value;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        checked_count++;
        if (expected_outcomes.size() == 0) begin
          report_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                    checked_count));
        end else begin
          want = expected_outcomes.pop_front();
          if (ok_o !== want.ok) begin
            report_mismatch($sformatf("beat %0d ok got %b want %b",
                                      checked_count, ok_o, want.ok));
          end
          if (head_value_o !== want.head) begin
            report_mismatch($sformatf("beat %0d head_value got %0d want %0d",
                                      checked_count, head_value_o, want.head));
          end
          if (found_index_o !== want.index) begin
            report_mismatch($sformatf("beat %0d found_index got %0d want %0d",
                                      checked_count, found_index_o, want.index));
          end
          if (count_o !== want.count) begin
            report_mismatch($sformatf("beat %0d count got %0d want %0d",
                                      checked_count, count_o, want.count));
          end
        end
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d cycles without a beat", quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] value;
    int                       mode;
    int                       roll;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = CMD_INSERT;
    value_i       = '0;
    out_stall_i   = 1'b0;
    list_fill     = 0;
    sent_count    = 0;
    checked_count = 0;
    error_count   = 0;
    full_rejects  = 0;
    empty_rejects = 0;
    search_hits   = 0;
    quiet_cycles  = 0;

    // Directed: empty list, extremes, duplicates, misses, full list.
    queue_request(CMD_REMOVE, 32'sd0, 1'b0);
    queue_request(CMD_SEARCH, 32'sd0, 1'b0);
    queue_request(CMD_NOP, -32'sd1, 1'b0);
    queue_request(CMD_INSERT, 32'sh7fffffff, 1'b0);
    queue_request(CMD_INSERT, 32'sh80000000, 1'b0);
    queue_request(CMD_INSERT, 32'sd0, 1'b0);
    queue_request(CMD_INSERT, -32'sd1, 1'b0);
    queue_request(CMD_INSERT, 32'sd0, 1'b0);
    queue_request(CMD_SEARCH, 32'sd0, 1'b0);
    queue_request(CMD_SEARCH, 32'sh80000000, 1'b0);
    queue_request(CMD_SEARCH, 32'sh7fffffff, 1'b0);
    queue_request(CMD_SEARCH, 32'sd1, 1'b0);
    for (int i = 0; i < 11; i++) begin
      queue_request(CMD_INSERT, i * 7 - 30, 1'b0);
    end
    queue_request(CMD_INSERT, 32'sd5, 1'b0);
    queue_request(CMD_REMOVE, 32'sh55555555, 1'b0);

    // Random: phases that favour filling, draining or a mix.
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      mode = (n / 40) % 3;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        cmd = CMD_NOP;
      end else if (roll < 20) begin
        cmd = CMD_SEARCH;
      end else if (mode == 0) begin
        cmd = (roll < 85) ? CMD_INSERT : CMD_REMOVE;
      end else if (mode == 1) begin
        cmd = (roll < 35) ? CMD_INSERT : CMD_REMOVE;
      end else begin
        cmd = (roll < 60) ? CMD_INSERT : CMD_REMOVE;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: value = $signed($urandom_range(0, 8)) - 4;
        5: begin
          case ($urandom_range(0, 3))
            0: value = 32'sh80000000;
            1: value = 32'sh7fffffff;
            2: value = 32'sd0;
            default: value = -32'sd1;
          endcase
        end
        default: value = $urandom;
      endcase
      queue_request(cmd, value, (n == 0) || (n == RANDOM_CMDS / 2));
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    do begin
      @(negedge clk_i);
    end while (pending_requests.size() != 0 || in_valid_i || expected_outcomes.size() != 0);
    repeat (8) @(posedge clk_i);

    $display("%0d commands sent and %0d results checked, %0d search hits",
             sent_count, checked_count, search_hits);
    $display("inserts refused on a full list: %0d, removes on an empty list: %0d",
             full_rejects, empty_rejects);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
